// ===== sv/assert_macros.svh =====
// Assertion macros shared by the bridge RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

// Invariant on every cycle out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

`endif

// ===== sv/lbfd_pkg.sv =====
// Package for the learning bridge forward decision block.
// Types and constants used by the bridge files, and the slot hash.
`timescale 1ns / 1ps

package lbfd_pkg;

  // Table depth must be a power of two: the slot is the low bits of the hash.
  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int PORTS       = 4;
  localparam int PORT_W      = $clog2(PORTS);
  localparam int MAC_W       = 48;
  localparam int MOVES_W     = 3;
  localparam int VERDICT_W   = 3;
  localparam int LOCAL_MACS  = 4;
  localparam int PCOUNT_W    = 3;
  localparam int LIMIT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int HASH_W      = 16;
  localparam int MCAST_BIT   = 40;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(3);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC_0    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC_1    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC_2    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_MAC_3    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_PORT_COUNT     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_MUTE_MASK      = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] CFG_RELOCATION_LIM = CFG_IDX_W'(6);

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_BCAST   = 3'd0,
    VERDICT_MCAST   = 3'd1,
    VERDICT_LOCAL   = 3'd2,
    VERDICT_UNKNOWN = 3'd3,
    VERDICT_DROP    = 3'd4,
    VERDICT_FORWARD = 3'd5
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LEARN,
    ST_DST_RD,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [MAC_W-1:0]   mac;
    logic [PORT_W-1:0]  port;
    logic [MOVES_W-1:0] moves;
  } entry_t;

  typedef struct packed {
    logic capture;   // frame transfer: latch header, read source slot
    logic learn;     // write back source entry
    logic dst_rd;    // read destination slot
    logic load_out;  // load result register
  } cmd_t;

  typedef struct packed {
    logic drop;      // source moved, new move count within relocation limit
  } status_t;

  function automatic logic [IDX_W-1:0] slot_of(logic [MAC_W-1:0] mac);
    logic [HASH_W-1:0] h;
    h = mac[2*HASH_W-1:HASH_W] ^ mac[HASH_W-1:0];
    return h[IDX_W-1:0];
  endfunction

endpackage

// ===== sv/lbfd_in_if.sv =====
// Frame header channel: valid/ready plus ingress port and MAC pair.
// Depends on lbfd_pkg.
`timescale 1ns / 1ps

interface lbfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [lbfd_pkg::PORT_W-1:0] in_port;
  logic [lbfd_pkg::MAC_W-1:0]  src_mac;
  logic [lbfd_pkg::MAC_W-1:0]  dst_mac;

  modport source (output valid, in_port, src_mac, dst_mac, input ready);
  modport sink   (input valid, in_port, src_mac, dst_mac, output ready);
endinterface

// ===== sv/lbfd_out_if.sv =====
// Decision channel: valid/ready plus verdict and egress port.
// Depends on lbfd_pkg.
`timescale 1ns / 1ps

interface lbfd_out_if;
  logic                           valid;
  logic                           ready;
  logic [lbfd_pkg::VERDICT_W-1:0] verdict;
  logic [lbfd_pkg::PORT_W-1:0]    out_port;

  modport source (output valid, verdict, out_port, input ready);
  modport sink   (input valid, verdict, out_port, output ready);
endinterface

// ===== sv/lbfd_ctrl.sv =====
// Sequencer for the bridge: steps each frame through the table port.
// Depends on lbfd_pkg.
`timescale 1ns / 1ps

module lbfd_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  lbfd_pkg::status_t  status,
  output lbfd_pkg::cmd_t     cmd
);

  lbfd_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lbfd_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = lbfd_pkg::ST_LEARN;
      end
      lbfd_pkg::ST_LEARN: begin
        state_nxt = status.drop ? lbfd_pkg::ST_RESULT : lbfd_pkg::ST_DST_RD;
      end
      lbfd_pkg::ST_DST_RD: begin
        state_nxt = lbfd_pkg::ST_RESULT;
      end
      lbfd_pkg::ST_RESULT: begin
        if (out_free) state_nxt = lbfd_pkg::ST_IDLE;
      end
      default: state_nxt = lbfd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lbfd_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      lbfd_pkg::ST_LEARN:  cmd.learn    = 1'b1;
      lbfd_pkg::ST_DST_RD: cmd.dst_rd   = 1'b1;
      lbfd_pkg::ST_RESULT: cmd.load_out = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lbfd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/lbfd_datapath.sv =====
// Bridge datapath: config registers, MAC table memory, learn and classify logic.
// Depends on lbfd_pkg; driven by lbfd_ctrl commands.
`timescale 1ns / 1ps

module lbfd_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [lbfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbfd_pkg::MAC_W-1:0]     cfg_wdata,
  input  logic [lbfd_pkg::PORT_W-1:0]    in_port,
  input  logic [lbfd_pkg::MAC_W-1:0]     src_mac,
  input  logic [lbfd_pkg::MAC_W-1:0]     dst_mac,
  input  lbfd_pkg::cmd_t                 cmd,
  output lbfd_pkg::status_t              status,
  output logic [lbfd_pkg::VERDICT_W-1:0] verdict,
  output logic [lbfd_pkg::PORT_W-1:0]    out_port
);

  localparam int MAC_W   = lbfd_pkg::MAC_W;
  localparam int PORT_W  = lbfd_pkg::PORT_W;
  localparam int MOVES_W = lbfd_pkg::MOVES_W;
  localparam int IDX_W   = lbfd_pkg::IDX_W;

  // Config registers
  logic [MAC_W-1:0]                local_mac_r [lbfd_pkg::LOCAL_MACS];
  logic [lbfd_pkg::PCOUNT_W-1:0]   port_count_r;
  logic [lbfd_pkg::PORTS-1:0]      mute_mask_r;
  logic [lbfd_pkg::LIMIT_W-1:0]    reloc_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lbfd_pkg::LOCAL_MACS; i++) local_mac_r[i] <= '0;
      port_count_r  <= '0;
      mute_mask_r   <= '0;
      reloc_limit_r <= lbfd_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lbfd_pkg::CFG_LOCAL_MAC_0:    local_mac_r[0] <= cfg_wdata;
        lbfd_pkg::CFG_LOCAL_MAC_1:    local_mac_r[1] <= cfg_wdata;
        lbfd_pkg::CFG_LOCAL_MAC_2:    local_mac_r[2] <= cfg_wdata;
        lbfd_pkg::CFG_LOCAL_MAC_3:    local_mac_r[3] <= cfg_wdata;
        lbfd_pkg::CFG_PORT_COUNT:     port_count_r  <= cfg_wdata[lbfd_pkg::PCOUNT_W-1:0];
        lbfd_pkg::CFG_MUTE_MASK:      mute_mask_r   <= cfg_wdata[lbfd_pkg::PORTS-1:0];
        lbfd_pkg::CFG_RELOCATION_LIM: reloc_limit_r <= cfg_wdata[lbfd_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame header latch
  logic [PORT_W-1:0] ip_r;
  logic [MAC_W-1:0]  src_r, dst_r;
  logic [IDX_W-1:0]  src_slot_r, dst_slot_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ip_r       <= in_port;
      src_r      <= src_mac;
      dst_r      <= dst_mac;
      src_slot_r <= lbfd_pkg::slot_of(src_mac);
      dst_slot_r <= lbfd_pkg::slot_of(dst_mac);
    end
  end

  // Table: valid flops plus single-port entry memory
  logic [lbfd_pkg::TABLE_DEPTH-1:0] valid_r;
  lbfd_pkg::entry_t                 mem [lbfd_pkg::TABLE_DEPTH];
  lbfd_pkg::entry_t                 rd_r;
  lbfd_pkg::entry_t                 wr_entry;
  logic [IDX_W-1:0]                 mem_addr;
  logic                             mem_re;

  always_comb begin
    if (cmd.capture)    mem_addr = lbfd_pkg::slot_of(src_mac);
    else if (cmd.learn) mem_addr = src_slot_r;
    else                mem_addr = dst_slot_r;
  end

  assign mem_re = cmd.capture || cmd.dst_rd;

  always_ff @(posedge clk) begin
    if (cmd.learn) mem[mem_addr] <= wr_entry;
    if (mem_re)    rd_r <= mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n)         valid_r <= '0;
    else if (cmd.learn) valid_r[src_slot_r] <= 1'b1;
  end

  // Source learning
  logic               src_hit, moved, reloc, drop;
  logic [MOVES_W:0]   cnt;
  logic [MOVES_W-1:0] cnt_sat;
  logic               drop_r, reloc_r;

  always_comb begin
    src_hit = valid_r[src_slot_r] && (rd_r.mac == src_r);
    moved   = src_hit && (rd_r.port != ip_r);
    cnt     = {1'b0, rd_r.moves} + (MOVES_W+1)'(1);
    cnt_sat = cnt[MOVES_W] ? '1 : cnt[MOVES_W-1:0];
    reloc   = moved && (cnt > {1'b0, reloc_limit_r});
    drop    = moved && !reloc;
    wr_entry.mac   = src_r;
    wr_entry.port  = drop ? rd_r.port : ip_r;
    wr_entry.moves = moved ? cnt_sat : '0;
  end

  assign status.drop = drop;

  always_ff @(posedge clk) begin
    if (cmd.learn) begin
      drop_r  <= drop;
      reloc_r <= reloc;
    end
  end

  // Destination classification
  logic [lbfd_pkg::PCOUNT_W-1:0] n_local;
  logic                          is_bcast, is_mcast, is_local, is_known, muted;
  lbfd_pkg::verdict_t            v;
  logic [PORT_W-1:0]             v_port;

  always_comb begin
    n_local = (port_count_r > lbfd_pkg::PCOUNT_W'(lbfd_pkg::LOCAL_MACS))
              ? lbfd_pkg::PCOUNT_W'(lbfd_pkg::LOCAL_MACS) : port_count_r;
    is_local = 1'b0;
    for (int i = 0; i < lbfd_pkg::LOCAL_MACS; i++) begin
      if ((lbfd_pkg::PCOUNT_W'(i) < n_local) && (local_mac_r[i] == dst_r)) is_local = 1'b1;
    end
    is_bcast = (dst_r == '1);
    is_mcast = dst_r[lbfd_pkg::MCAST_BIT];
    is_known = valid_r[dst_slot_r] && (rd_r.mac == dst_r);
    muted    = mute_mask_r[ip_r] || reloc_r;
    v_port   = '0;
    if (drop_r) begin
      v = lbfd_pkg::VERDICT_DROP;
    end else if (muted) begin
      v = (is_bcast || is_mcast || is_local) ? lbfd_pkg::VERDICT_LOCAL
                                             : lbfd_pkg::VERDICT_DROP;
    end else if (is_bcast) begin
      v = lbfd_pkg::VERDICT_BCAST;
    end else if (is_mcast) begin
      v = lbfd_pkg::VERDICT_MCAST;
    end else if (is_local) begin
      v = lbfd_pkg::VERDICT_LOCAL;
    end else if (is_known) begin
      if (rd_r.port == ip_r) begin
        v = lbfd_pkg::VERDICT_DROP;
      end else begin
        v      = lbfd_pkg::VERDICT_FORWARD;
        v_port = rd_r.port;
      end
    end else begin
      v = lbfd_pkg::VERDICT_UNKNOWN;
    end
  end

  // Result register
  logic [lbfd_pkg::VERDICT_W-1:0] verdict_r;
  logic [PORT_W-1:0]              out_port_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      verdict_r  <= v;
      out_port_r <= v_port;
    end
  end

  assign verdict  = verdict_r;
  assign out_port = out_port_r;

endmodule

// ===== sv/learning_bridge_forward_decision_core.sv =====
// Top level of the learning bridge forward decision block.
// Depends on lbfd_pkg, lbfd_in_if, lbfd_out_if, lbfd_ctrl, lbfd_datapath.
`timescale 1ns / 1ps

// One frame header goes in per transfer and one decision comes out. The source
// MAC is learned in a direct-mapped table (slot = low bits of MAC[31:16] ^
// MAC[15:0]); the destination is then classified as broadcast, multicast,
// local, forward to a known port, or unknown flood, with muting and
// same-port drop applied. A frame holds the block from its transfer until its
// result is loaded: the single table port serves the source read at the
// transfer, the source write-back and the destination read in turn (the
// destination read is skipped when the frame is dropped for a port move
// within the relocation limit), and a last step loads the result into the
// output register, which offers it. The load waits while the output register
// holds a result that is not taken. The input takes the next frame in the
// cycle after the result is loaded, while that result may still wait in the
// output register. Valid bits are flip-flops cleared by reset, so there is no
// clearing pass. The user must make configuration writes only while the block
// is idle; the block itself does not enforce it. They never flush the table.
module learning_bridge_forward_decision_core (
  input  logic                           clk,
  input  logic                           rst_n,
  lbfd_in_if.sink                        in_if,
  lbfd_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [lbfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbfd_pkg::MAC_W-1:0]     cfg_wdata
);

`include "assert_macros.svh"

  lbfd_pkg::cmd_t    cmd;
  lbfd_pkg::status_t status;

  // Sequencer owns both handshakes.
  lbfd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds config, table and result payload.
  lbfd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_port   (in_if.in_port),
    .src_mac   (in_if.src_mac),
    .dst_mac   (in_if.dst_mac),
    .cmd       (cmd),
    .status    (status),
    .verdict   (out_if.verdict),
    .out_port  (out_if.out_port)
  );

  // The table port is used by at most one step per cycle.
  `ASSERT_ALWAYS(a_one_port_op, clk, rst_n,
    $onehot0({cmd.capture, cmd.learn, cmd.dst_rd, cmd.load_out}))
  // A result never overwrites one that has not been taken.
  `ASSERT_IMPL(a_load_free, clk, rst_n, cmd.load_out, (!out_if.valid || out_if.ready))
  // After a frame transfer the block is busy with it.
  `ASSERT_NEXT(a_busy_after_xfer, clk, rst_n, (in_if.valid && in_if.ready), !in_if.ready)

endmodule
